FILE: hdl/isbs_pkg.sv
// isbs_pkg: shared widths, operation codes and status codes for the
// bounded search stack. No dependencies.
`timescale 1ns / 1ps

package isbs_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int WORD_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  // stream word widths, padded to whole bytes
  localparam int IN_DATA_W  = 2 * WORD_W;
  localparam int OUT_BITS   = WORD_W + 3 + STATUS_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;

endpackage

FILE: hdl/isbs_ram.sv
// isbs_ram: generic simple dual-port RAM, one write and one registered
// read port. No dependencies.
`timescale 1ns / 1ps

module isbs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/int_stack_with_bounded_search.sv
// int_stack_with_bounded_search: LIFO of signed 32-bit words with a downward
// search bounded by a limit word. Depends on isbs_pkg and isbs_ram.
// Steps: a push that fits writes the new top and scans down from the old
// top; pop, probe and a dropped push read the top, then scan below it; an op
// that starts or ends on an empty stack goes straight to the result. One item
// in flight; a new word is taken once the previous result has moved into the
// output register. The single RAM read port, one entry per cycle, sets the
// scan time. Synchronous active-high rst clears the fill count and control;
// RAM contents are undefined until pushed.
`timescale 1ns / 1ps

module int_stack_with_bounded_search
  import isbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input word
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // [31:0] value, [63:32] limit
  input  logic [KIND_W-1:0]     s_tuser,  // [1:0] kind
  // result word
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata   // [31:0] top_word, [32] empty_res,
                                          // [33] found_under, [34] directly_under,
                                          // [36:35] status, [39:37] zero
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TOP,     // read of the top entry in flight
    S_SCAN,    // read of an entry below the top in flight
    S_FINISH   // result ready, waiting for the output register
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]    cnt, cnt_next;      // entries held
  logic [ADDR_W-1:0]   cur, cur_next;      // address of read in flight
  logic [WORD_W-1:0]   key, key_next;
  logic [WORD_W-1:0]   lim, lim_next;
  logic [WORD_W-1:0]   top, top_next;
  logic                under, under_next;
  logic                found, found_next;
  logic                first, first_next;  // next scanned entry is just below top
  logic [STATUS_W-1:0] status, status_next;

  // RAM port
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;

  logic [CNT_W-1:0]  cnt_m1, cnt_m2;
  logic [ADDR_W-1:0] cur_m1;
  logic              load_out;

  isbs_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (s_tdata[WORD_W-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign s_tready = (state == S_IDLE);
  assign cnt_m1   = cnt - CNT_W'(1);
  assign cnt_m2   = cnt - CNT_W'(2);
  assign cur_m1   = cur - ADDR_W'(1);
  assign wr_addr  = cnt[ADDR_W-1:0];
  assign load_out = (state == S_FINISH) && (!m_tvalid || m_tready);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    cur_next    = cur;
    key_next    = key;
    lim_next    = lim;
    top_next    = top;
    under_next  = under;
    found_next  = found;
    first_next  = first;
    status_next = status;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = cur;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          key_next    = s_tdata[WORD_W-1:0];
          lim_next    = s_tdata[2*WORD_W-1:WORD_W];
          top_next    = '0;
          under_next  = 1'b0;
          found_next  = 1'b0;
          first_next  = 1'b1;
          status_next = STAT_OK;
          case (s_tuser)
            KIND_PUSH: begin
              if (cnt == CNT_W'(STACK_DEPTH)) begin
                // full: drop, report current top
                status_next = STAT_OVERFLOW;
                rd_en       = 1'b1;
                rd_addr     = cnt_m1[ADDR_W-1:0];
                cur_next    = cnt_m1[ADDR_W-1:0];
                state_next  = S_TOP;
              end else begin
                // new top is the pushed word; scan starts at the old top
                wr_en    = 1'b1;
                cnt_next = cnt + CNT_W'(1);
                top_next = s_tdata[WORD_W-1:0];
                if (cnt != '0) begin
                  rd_en      = 1'b1;
                  rd_addr    = cnt_m1[ADDR_W-1:0];
                  cur_next   = cnt_m1[ADDR_W-1:0];
                  state_next = S_SCAN;
                end else begin
                  state_next = S_FINISH;
                end
              end
            end
            KIND_POP: begin
              if (cnt == '0) begin
                status_next = STAT_UNDERFLOW;
                state_next  = S_FINISH;
              end else begin
                cnt_next = cnt_m1;
                if (cnt_m1 != '0) begin
                  rd_en      = 1'b1;
                  rd_addr    = cnt_m2[ADDR_W-1:0];
                  cur_next   = cnt_m2[ADDR_W-1:0];
                  state_next = S_TOP;
                end else begin
                  state_next = S_FINISH;
                end
              end
            end
            default: begin
              // probe, and the unused code
              if (cnt == '0) begin
                status_next = STAT_UNDERFLOW;
                state_next  = S_FINISH;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = cnt_m1[ADDR_W-1:0];
                cur_next   = cnt_m1[ADDR_W-1:0];
                state_next = S_TOP;
              end
            end
          endcase
        end
      end

      S_TOP: begin
        top_next = rd_data;
        if (cnt > CNT_W'(1)) begin
          rd_en      = 1'b1;
          rd_addr    = cur_m1;
          cur_next   = cur_m1;
          state_next = S_SCAN;
        end else begin
          state_next = S_FINISH;
        end
      end

      S_SCAN: begin
        first_next = 1'b0;
        if (first) begin
          under_next = (rd_data == key);
        end
        // value match wins over limit match at the same entry
        if (rd_data == key) begin
          found_next = 1'b1;
          state_next = S_FINISH;
        end else if (rd_data == lim) begin
          state_next = S_FINISH;
        end else if (cur == '0) begin
          state_next = S_FINISH;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = cur_m1;
          cur_next = cur_m1;
        end
      end

      S_FINISH: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {(OUT_DATA_W - OUT_BITS)'(0), status, under, found,
                     (cnt == '0), top};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur    <= cur_next;
    key    <= key_next;
    lim    <= lim_next;
    top    <= top_next;
    under  <= under_next;
    found  <= found_next;
    first  <= first_next;
    status <= status_next;
  end

endmodule

FILE: tb/sv/isbs_checker.sv
// isbs_checker: watches both stream channels of the bounded search stack,
// predicts each result word and compares it field by field. Depends on isbs_pkg.
`timescale 1ns / 1ps

module isbs_checker
  import isbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [KIND_W-1:0]     s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  output int                    fail_count,
  output int                    reports_owed
);

  // same bit order as m_tdata, top_word lowest
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                directly_under;
    logic                found_under;
    logic                empty_res;
    logic [WORD_W-1:0]   top_word;
  } stack_report_t;

  logic [WORD_W-1:0] shadow_words [STACK_DEPTH];
  int                held = 0;
  stack_report_t     owed_q [$];
  int                words_seen = 0;

  initial begin
    fail_count   = 0;
    reports_owed = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: result word %0d: %s", $time, words_seen, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
    if (got !== want)
      report_mismatch($sformatf("%s expected %h got %h", name, want, got));
  endtask

  // applies one operation to the shadow stack and returns what the block reports
  function automatic stack_report_t stack_op_outcome(input logic [KIND_W-1:0] kind,
                                                     input logic [WORD_W-1:0] value,
                                                     input logic [WORD_W-1:0] limit);
    stack_report_t r;
    int            i;
    r = '0;
    case (kind)
      KIND_PUSH: begin
        if (held >= STACK_DEPTH) begin
          r.status = STAT_OVERFLOW;
        end else begin
          shadow_words[held] = value;
          held++;
        end
      end
      KIND_POP: begin
        if (held == 0) r.status = STAT_UNDERFLOW;
        else held--;
      end
      default: begin  // probe, spare code included
        if (held == 0) r.status = STAT_UNDERFLOW;
      end
    endcase
    r.empty_res = (held == 0);
    if (held > 0) r.top_word = shadow_words[held-1];
    if (held > 1) r.directly_under = (shadow_words[held-2] == value);
    // downward scan below top; key match checked before limit match
    i = held - 2;
    while (i >= 0) begin
      if (shadow_words[i] == value) begin
        r.found_under = 1'b1;
        break;
      end
      if (shadow_words[i] == limit) break;
      i--;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    stack_report_t want, got;
    if (rst) begin
      held = 0;
      owed_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[OUT_BITS-1:0];
        if (owed_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", m_tdata));
        end else begin
          want = owed_q.pop_front();
          compare_field("top_word", want.top_word, got.top_word);
          compare_field("empty_res", want.empty_res, got.empty_res);
          compare_field("found_under", want.found_under, got.found_under);
          compare_field("directly_under", want.directly_under, got.directly_under);
          compare_field("status", want.status, got.status);
        end
        words_seen++;
      end
      if (s_tvalid && s_tready)
        owed_q.push_back(stack_op_outcome(s_tuser, s_tdata[WORD_W-1:0],
                                          s_tdata[2*WORD_W-1:WORD_W]));
    end
    reports_owed <= owed_q.size();
  end

endmodule

FILE: tb/sv/int_stack_with_bounded_search_tb.sv
// int_stack_with_bounded_search_tb: drives push/pop/probe words into the stack
// and stalls the result side; isbs_checker predicts and compares.
// Depends on isbs_pkg, isbs_checker and the int_stack_with_bounded_search RTL.
`timescale 1ns / 1ps

module int_stack_with_bounded_search_tb;
  import isbs_pkg::*;

  // probe codes; the block treats the spare code as a probe
  localparam logic [KIND_W-1:0] KIND_PROBE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

  localparam int ITEM_TARGET = 650;
  // quiet cycles allowed: worst scan plus longest source gap and sink stall, x4
  localparam int IDLE_LIMIT  = 4 * (STACK_DEPTH + 3 + 2 * 40) + 100;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [KIND_W-1:0]     s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int fail_count;
  int reports_owed;
  int words_sent = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;  // when set, neither side inserts gaps

  always #5 clk = ~clk;

  int_stack_with_bounded_search uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [31:0] value, [63:32] limit
    .s_tuser  (s_tuser),   // [1:0] kind
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [31:0] top_word, [32] empty_res, [33] found_under,
                           // [34] directly_under, [36:35] status
  );

  isbs_checker chk (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .fail_count   (fail_count),
    .reports_owed (reports_owed)
  );

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Word values: a small pool so that keys and limits actually hit stack
  // entries, plus the extremes and fully random words for bit coverage.
  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return WORD_W'($urandom_range(0, 8) - 4);
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0:       return WORD_MIN;
        1:       return WORD_MAX;
        2:       return '0;
        default: return WORD_ONES;
      endcase
    end
    return $urandom();
  endfunction

  // Present one word and hold it until the stack takes it. valid stays high
  // across back-to-back words so it is never dropped and raised in one step.
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value,
                           input logic [WORD_W-1:0] limit);
    int gap;
    gap = pick_pause();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {limit, value};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // Sink: runs of ready broken by stalls of random length.
  initial begin
    int gap;
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(40, 120)
                                        : $urandom_range(1, 12)) @(posedge clk);
      gap = pick_pause();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Watchdog: a run with no handshake for too long is hung.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d quiet cycles", idle_cycles);
      $display("int_stack_with_bounded_search regression: fail");
      $finish;
    end
  end

  initial begin
    int ep_len, ep_type, w_push, w_pop, r;
    logic [KIND_W-1:0] kind;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // pop, probe and the spare code on an empty stack report underflow
    send_word(KIND_PROBE, 32'd5, 32'd6);
    send_word(KIND_POP,   32'd5, 32'd6);
    send_word(KIND_SPARE, 32'd5, 32'd6);
    // stack bottom to top: min, 7, max, -1, 7
    send_word(KIND_PUSH, WORD_MIN,  '0);
    send_word(KIND_PUSH, 32'd7,     '0);
    send_word(KIND_PUSH, WORD_MAX,  '0);
    send_word(KIND_PUSH, WORD_ONES, '0);
    send_word(KIND_PUSH, 32'd7,     '0);
    send_word(KIND_PROBE, 32'd7, 32'd9);      // key found deep below top
    send_word(KIND_PROBE, 32'd7, WORD_MAX);   // limit word met first
    send_word(KIND_PROBE, WORD_ONES, WORD_ONES); // key equals limit: key wins
    send_word(KIND_SPARE, WORD_MIN, '0);      // spare code, key at the bottom
    send_word(KIND_PUSH, '0, '0);
    send_word(KIND_PROBE, '0, '0);            // key only on top, not below
    // drain to empty, then one pop too many
    repeat (7) send_word(KIND_POP, 32'd7, WORD_MIN);

    // --- random episodes ---
    // fill and drain runs reach overflow and underflow; mixed and probe-heavy
    // runs keep the search busy at mid depth
    while (words_sent < ITEM_TARGET) begin
      ep_type = $urandom_range(0, 3);
      ep_len  = $urandom_range(30, 90);
      steady  = ($urandom_range(0, 3) == 0);
      case (ep_type)
        0:       begin w_push = 85; w_pop = 5;  end
        1:       begin w_push = 5;  w_pop = 85; end
        2:       begin w_push = 40; w_pop = 30; end
        default: begin w_push = 20; w_pop = 20; end
      endcase
      repeat (ep_len) begin
        r = $urandom_range(0, 99);
        if (r < w_push) kind = KIND_PUSH;
        else if (r < w_push + w_pop) kind = KIND_POP;
        else kind = ($urandom_range(0, 4) == 0) ? KIND_SPARE : KIND_PROBE;
        send_word(kind, pick_word(), pick_word());
      end
    end
    s_tvalid <= 1'b0;
    steady   <= 1'b0;

    // let the last prediction register, then drain results and the pipeline
    @(posedge clk);
    while (reports_owed != 0) @(posedge clk);
    repeat (STACK_DEPTH + 8) @(posedge clk);

    if (fail_count == 0) begin
      $display("int_stack_with_bounded_search regression: pass");
    end else begin
      $display("int_stack_with_bounded_search regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/isbs_pkg.sv
hdl/isbs_ram.sv
hdl/int_stack_with_bounded_search.sv
tb/sv/isbs_checker.sv
tb/sv/int_stack_with_bounded_search_tb.sv
